// ===== hdl/ilir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list package
// Operation and status codes, field widths and default sizes that the
// indexed list block shares between its files.
// ----------------------------------------------------------------------------
package ilir_pkg;

   // Field widths of the request and response words.
   localparam int OP_W        = 3;
   localparam int IDX_W       = 6;
   localparam int VAL_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   // Default list size and element width.
   localparam int DEPTH_DEFAULT      = 64;
   localparam int ELEM_WIDTH_DEFAULT = 32;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes.
   localparam op_type OP_INSERT      = 3'd0;
   localparam op_type OP_APPEND      = 3'd1;
   localparam op_type OP_GET         = 3'd2;
   localparam op_type OP_SET         = 3'd3;
   localparam op_type OP_REMOVE      = 3'd4;
   localparam op_type OP_REMOVE_LAST = 3'd5;

   // Status codes.
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/ilir_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data appears in the cycle
// after the read enable.
// ----------------------------------------------------------------------------
module ilir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/indexed_list_insert_remove.sv =====
`default_nettype none
// One element moves per cycle through the single read and write ports of the element
// RAM, which sets the time of insert and remove.
// A new word is accepted the cycle after the previous response is registered.
// Synchronous active-high reset empties the list; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Indexed list with insert and remove
// Ordered list held in a RAM with an element count. Insert and remove shift
// the later elements one place per cycle with a read-then-write pipeline.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
   parameter int DEPTH      = ilir_pkg::DEPTH_DEFAULT,
   parameter int ELEM_WIDTH = ilir_pkg::ELEM_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ilir_pkg::OP_W-1:0]           req_op,
   input  wire logic [ilir_pkg::IDX_W-1:0]          req_index,
   input  wire logic [ilir_pkg::VAL_W-1:0]          req_value_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [ilir_pkg::VAL_W-1:0]          rsp_value_out,
   output logic      [ilir_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [ilir_pkg::COUNT_OUT_W-1:0]    rsp_count_out
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > ilir_pkg::IDX_W) ? CNT_W : ilir_pkg::IDX_W;

   // Controller states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_RM   = 3'd2;
   localparam logic [2:0] S_GS   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              ptr_ff, ptr_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;
   logic [ELEM_WIDTH-1:0]         val_ff, val_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 pend_addr_ff, pend_addr_in;
   logic                          cap_ff, cap_in;
   logic                          set_ff, set_in;
   logic                          grow_ff, grow_in;
   logic                          shrink_ff, shrink_in;
   logic [ilir_pkg::VAL_W-1:0]    result_ff, result_in;
   ilir_pkg::status_type          status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ilir_pkg::VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   ilir_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [ilir_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [ELEM_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [ELEM_WIDTH-1:0] mem_rdata;

   logic [CMP_W-1:0] idx_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic [CNT_W-1:0] idx_cnt;
   logic [CNT_W-1:0] last_pos;
   logic [CNT_W-1:0] ptr_dec;
   logic             list_full;
   logic             list_empty;
   logic             out_free;
   logic             req_take;

   // Element store.
   ilir_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Request decode helpers.
   assign idx_cmp    = CMP_W'(req_index);
   assign cnt_cmp    = CMP_W'(count_ff);
   assign idx_cnt    = CNT_W'(req_index);
   assign last_pos   = count_ff - CNT_W'(1);
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign list_full  = (count_ff == CNT_W'(DEPTH));
   assign list_empty = (count_ff == '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && (state_ff == S_IDLE);

   // Controller: decode, shift pipeline and response load.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      cap_in        = cap_ff;
      set_in        = set_ff;
      grow_in       = grow_ff;
      shrink_in     = shrink_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = pend_addr_ff;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               result_in = '0;
               status_in = ilir_pkg::ST_OK;
               val_in    = ELEM_WIDTH'(req_value_in);
               pend_in   = 1'b0;
               cap_in    = 1'b0;
               set_in    = 1'b0;
               grow_in   = 1'b0;
               shrink_in = 1'b0;
               state_in  = S_FIN;
               case (req_op)
                  ilir_pkg::OP_INSERT, ilir_pkg::OP_APPEND: begin
                     if (req_op == ilir_pkg::OP_INSERT && idx_cmp > cnt_cmp) begin
                        status_in = ilir_pkg::ST_RANGE;
                     end else if (list_full) begin
                        status_in = ilir_pkg::ST_FULL;
                     end else begin
                        ptr_in   = count_ff;
                        pos_in   = (req_op == ilir_pkg::OP_INSERT) ? idx_cnt : count_ff;
                        grow_in  = 1'b1;
                        state_in = S_INS;
                     end
                  end
                  ilir_pkg::OP_GET, ilir_pkg::OP_SET: begin
                     if (list_empty) begin
                        status_in = ilir_pkg::ST_EMPTY;
                     end else if (idx_cmp >= cnt_cmp) begin
                        status_in = ilir_pkg::ST_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_cnt[AW-1:0];
                        pos_in    = idx_cnt;
                        set_in    = (req_op == ilir_pkg::OP_SET);
                        state_in  = S_GS;
                     end
                  end
                  ilir_pkg::OP_REMOVE: begin
                     if (list_empty) begin
                        status_in = ilir_pkg::ST_EMPTY;
                     end else if (idx_cmp >= cnt_cmp) begin
                        status_in = ilir_pkg::ST_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_cnt[AW-1:0];
                        ptr_in    = idx_cnt + CNT_W'(1);
                        cap_in    = 1'b1;
                        shrink_in = 1'b1;
                        state_in  = S_RM;
                     end
                  end
                  ilir_pkg::OP_REMOVE_LAST: begin
                     if (list_empty) begin
                        status_in = ilir_pkg::ST_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = last_pos[AW-1:0];
                        ptr_in    = count_ff;
                        cap_in    = 1'b1;
                        shrink_in = 1'b1;
                        state_in  = S_RM;
                     end
                  end
                  default: begin
                     status_in = ilir_pkg::ST_OK;
                  end
               endcase
            end
         end

         // Shift up: read entry ptr-1, write it to ptr in the next cycle,
         // then place the new element at its position.
         S_INS: begin
            if (pend_ff) begin
               mem_we  = 1'b1;
               pend_in = 1'b0;
            end else if (ptr_ff == pos_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[AW-1:0];
               mem_wdata = val_ff;
               state_in  = S_FIN;
            end
            if (ptr_ff > pos_ff) begin
               mem_re       = 1'b1;
               mem_raddr    = ptr_dec[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[AW-1:0];
               ptr_in       = ptr_dec;
            end
         end

         // Shift down: capture the removed element, then read entry ptr and
         // write it to ptr-1 in the next cycle until the end of the list.
         S_RM: begin
            if (cap_ff) begin
               result_in = ilir_pkg::VAL_W'(mem_rdata);
               cap_in    = 1'b0;
            end
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (ptr_ff < count_ff) begin
               mem_re       = 1'b1;
               mem_raddr    = ptr_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_dec[AW-1:0];
               ptr_in       = ptr_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff && !cap_ff) begin
                  state_in = S_FIN;
               end
            end
         end

         // Get or set: return the stored element, overwrite it on set.
         S_GS: begin
            result_in = ilir_pkg::VAL_W'(mem_rdata);
            if (set_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[AW-1:0];
               mem_wdata = val_ff;
            end
            state_in = S_FIN;
         end

         // Commit the count and load the response word.
         S_FIN: begin
            if (out_free) begin
               if (grow_ff) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (shrink_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_value_in  = result_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = ilir_pkg::COUNT_OUT_W'(count_in);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      pend_addr_ff  <= pend_addr_in;
      set_ff        <= set_in;
      grow_ff       <= grow_in;
      shrink_ff     <= shrink_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // The element count never exceeds the list capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above capacity");

   // The count only changes when a response word is committed.
   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff) == S_FIN)
      else $error("count changed outside commit");

   // The shift pipeline never reads and writes the same entry in one cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && mem_waddr == mem_raddr))
      else $error("read and write of the same entry in one cycle");

   // A shift write is only pending inside an insert or remove.
   a_pend_state: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_INS || state_ff == S_RM))
      else $error("pending shift write outside insert or remove");
`endif

endmodule
`default_nettype wire
